[src/bmp_1bit_blit_to_framebuffer_top_defines.svh]
// assertion macros for the one-bit bmp blitter
// used by the top level; expects clk_i and rst_ni in the including scope
`ifndef BMP_1BIT_BLIT_TO_FRAMEBUFFER_TOP_DEFINES_SVH
`define BMP_1BIT_BLIT_TO_FRAMEBUFFER_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
`define BMPBLIT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define BMPBLIT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);
`else
`define BMPBLIT_ASSERT(lbl, prop, msg)
`define BMPBLIT_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

[src/bmpblit_pkg.sv]
// shared types, codes and constants of the one-bit bmp blitter
// no dependencies
`timescale 1ns / 1ps

package bmpblit_pkg;

  localparam int FB_ROW_BYTES_DEF = 12;
  localparam int FB_ROWS_DEF      = 48;

  localparam int               POS_W          = 14;
  localparam logic [POS_W-1:0] POS_MAX        = 14'h3fff;
  localparam logic [POS_W-1:0] HDR_OFFSET_POS = 14'd10;
  localparam logic [POS_W-1:0] HDR_WIDTH_POS  = 14'd18;
  localparam logic [POS_W-1:0] HDR_HEIGHT_POS = 14'd22;
  localparam int               RECIP_SHIFT    = 14;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_BLIT  = 2'd1,
    OP_BYTE  = 2'd2,
    OP_READ  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_CLIP      = 2'd1,
    ST_NOT_PIXEL = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [7:0]        data_byte;
    logic signed [7:0] dest_x;
    logic signed [7:0] dest_y;
    logic [9:0]        read_index;
  } bmpblit_in_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [1:0] status;
    logic       image_done;
  } bmpblit_out_t;

  typedef struct packed {
    logic load;
    logic decode;
    logic div1;
    logic div2;
    logic div3;
    logic plan;
    logic rd_lo;
    logic wr_lo;
    logic wr_hi;
    logic clr;
    logic rd_cap;
  } bmpblit_cmd_t;

  typedef struct packed {
    op_e  op;
    logic is_pixel;
    logic clr_last;
  } bmpblit_sts_t;

  // floor(2^14 / d) for row widths of one to eight words
  function automatic logic [14:0] recip_of(input logic [3:0] d);
    logic [14:0] r;
    case (d)
      4'd1:    r = 15'd16384;
      4'd2:    r = 15'd8192;
      4'd3:    r = 15'd5461;
      4'd4:    r = 15'd4096;
      4'd5:    r = 15'd3276;
      4'd6:    r = 15'd2730;
      4'd7:    r = 15'd2340;
      4'd8:    r = 15'd2048;
      default: r = 15'd0;
    endcase
    return r;
  endfunction

endpackage

[src/bmp_1bit_blit_to_framebuffer_top.sv]
// After accept each transaction is decoded. Start blit and non-pixel bytes then go straight
// to the result strobe; a framebuffer read first captures the registered ram read; a pixel
// byte runs the divide steps, mask planning and a read-modify-write of up to two bytes; a
// clear writes every entry, one entry a cycle. A new transaction is taken only when idle.
// After reset a clearing sweep over all FB_BYTES entries (576 by default) holds busy high.
// The receiver cannot stall: each result is shown for exactly one cycle.
`timescale 1ns / 1ps
`include "bmp_1bit_blit_to_framebuffer_top_defines.svh"

module bmp_1bit_blit_to_framebuffer_top #(
  parameter int FB_ROW_BYTES = bmpblit_pkg::FB_ROW_BYTES_DEF,
  parameter int FB_ROWS      = bmpblit_pkg::FB_ROWS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  bmpblit_pkg::bmpblit_in_t  item_i,
  output logic                      result_valid_o,
  output bmpblit_pkg::bmpblit_out_t result_o
);
  import bmpblit_pkg::*;

  // command and status between controller and datapath
  bmpblit_cmd_t cmd;
  bmpblit_sts_t sts;

  // controller: sequences decode, the split of the byte index into source row
  // and column byte, mask planning, the two-byte read-modify-write and clears
  bmpblit_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .sts_i         (sts),
    .cmd_o         (cmd),
    .busy_o        (busy),
    .result_valid_o(result_valid_o)
  );

  // datapath: holds the header/offset context, the framebuffer ram and the
  // result register that the strobe qualifies
  bmpblit_dp #(
    .FB_ROW_BYTES(FB_ROW_BYTES),
    .FB_ROWS     (FB_ROWS)
  ) u_dp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd),
    .item_i  (item_i),
    .sts_o   (sts),
    .result_o(result_o)
  );

  // a result only appears while the block still counts the transaction as in flight
  `BMPBLIT_ASSERT(a_result_while_busy, result_valid_o |-> busy, "result strobe while idle")
  // an accepted transaction keeps the block busy in the following cycle
  `BMPBLIT_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accept did not raise busy")
  // one result per transaction, shown for a single cycle
  `BMPBLIT_ASSERT_NEXT(a_strobe_single, result_valid_o, !result_valid_o, "strobe held")
  // read data only comes with a plain read result
  `BMPBLIT_ASSERT(a_read_clean,
    (result_valid_o && (result_o.read_data != 8'd0)) |->
      (result_o.status == ST_OK && !result_o.image_done),
    "read data with blit status")

endmodule

[src/bmpblit_ram.sv]
// generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module bmpblit_ram #(
  parameter int  WIDTH = 8,
  parameter int  DEPTH = 16,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[src/bmpblit_ctrl.sv]
// controller state machine of the one-bit bmp blitter
// depends on bmpblit_pkg
`timescale 1ns / 1ps

module bmpblit_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  bmpblit_pkg::bmpblit_sts_t sts_i,
  output bmpblit_pkg::bmpblit_cmd_t cmd_o,
  output logic                      busy_o,
  output logic                      result_valid_o
);
  import bmpblit_pkg::*;

  typedef enum logic [12:0] {
    S_INIT    = 13'b0000000000001,
    S_IDLE    = 13'b0000000000010,
    S_DECODE  = 13'b0000000000100,
    S_DIV1    = 13'b0000000001000,
    S_DIV2    = 13'b0000000010000,
    S_DIV3    = 13'b0000000100000,
    S_PLAN    = 13'b0000001000000,
    S_RD_LO   = 13'b0000010000000,
    S_WR_LO   = 13'b0000100000000,
    S_WR_HI   = 13'b0001000000000,
    S_CLEAR   = 13'b0010000000000,
    S_RD_WAIT = 13'b0100000000000,
    S_RESULT  = 13'b1000000000000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_INIT: begin
        cmd_o.clr = 1'b1;
        if (sts_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd_o.decode = 1'b1;
        case (sts_i.op)
          OP_CLEAR: state_d = S_CLEAR;
          OP_READ:  state_d = S_RD_WAIT;
          OP_BYTE:  state_d = sts_i.is_pixel ? S_DIV1 : S_RESULT;
          default:  state_d = S_RESULT;
        endcase
      end
      S_DIV1: begin
        cmd_o.div1 = 1'b1;
        state_d    = S_DIV2;
      end
      S_DIV2: begin
        cmd_o.div2 = 1'b1;
        state_d    = S_DIV3;
      end
      S_DIV3: begin
        cmd_o.div3 = 1'b1;
        state_d    = S_PLAN;
      end
      S_PLAN: begin
        cmd_o.plan = 1'b1;
        state_d    = S_RD_LO;
      end
      S_RD_LO: begin
        cmd_o.rd_lo = 1'b1;
        state_d     = S_WR_LO;
      end
      S_WR_LO: begin
        cmd_o.wr_lo = 1'b1;
        state_d     = S_WR_HI;
      end
      S_WR_HI: begin
        cmd_o.wr_hi = 1'b1;
        state_d     = S_RESULT;
      end
      S_CLEAR: begin
        cmd_o.clr = 1'b1;
        if (sts_i.clr_last) state_d = S_RESULT;
      end
      S_RD_WAIT: begin
        cmd_o.rd_cap = 1'b1;
        state_d      = S_RESULT;
      end
      S_RESULT: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy_o         = (state_q != S_IDLE);
  assign result_valid_o = (state_q == S_RESULT);

endmodule

[src/bmpblit_dp.sv]
// datapath of the one-bit bmp blitter: header capture, row/column split,
// clip and mask planning, framebuffer read-modify-write; depends on bmpblit_pkg, bmpblit_ram
`timescale 1ns / 1ps

module bmpblit_dp #(
  parameter int FB_ROW_BYTES = bmpblit_pkg::FB_ROW_BYTES_DEF,
  parameter int FB_ROWS      = bmpblit_pkg::FB_ROWS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  bmpblit_pkg::bmpblit_cmd_t cmd_i,
  input  bmpblit_pkg::bmpblit_in_t  item_i,
  output bmpblit_pkg::bmpblit_sts_t sts_o,
  output bmpblit_pkg::bmpblit_out_t result_o
);
  import bmpblit_pkg::*;

  localparam int FB_BYTES = FB_ROW_BYTES * FB_ROWS;
  localparam int AW       = (FB_BYTES > 1) ? $clog2(FB_BYTES) : 1;

  localparam logic signed [10:0] ROWS_S   = 11'(FB_ROWS);
  localparam logic signed [7:0]  COLS_S   = 8'(FB_ROW_BYTES);
  localparam logic signed [15:0] RB_S     = 16'(FB_ROW_BYTES);
  localparam logic [13:0]        FB_BYTES_W = 14'(FB_BYTES);
  localparam logic [AW-1:0]      CLR_LAST = AW'(FB_BYTES - 1);

  bmpblit_in_t  item_q;
  bmpblit_out_t res_q;

  logic [POS_W-1:0]  pos_q;
  logic [7:0]        pix_start_q, img_w_q, img_h_q;
  logic signed [7:0] off_x_q, off_y_q;
  logic [AW-1:0]     clr_ptr_q;

  logic [12:0] idx_q;
  logic [3:0]  words_q;
  logic        done_q;
  logic [25:0] prod_q;
  logic [10:0] quo_q;
  logic [4:0]  rem_q;
  logic [7:0]  src_row_q;
  logic [4:0]  col_byte_q;
  logic [AW-1:0] addr_lo_q, addr_hi_q;
  logic [7:0]  mask_lo_q, mask_hi_q;
  logic        lo_ok_q, hi_ok_q;

  // header capture and pixel test for the byte in hand
  logic [7:0]       ps_eff, w_eff, h_eff;
  logic [8:0]       w_sum;
  logic [3:0]       words;
  logic [5:0]       row_bytes;
  logic [13:0]      total, diff;
  logic             is_pixel, is_last;

  assign ps_eff    = (pos_q == HDR_OFFSET_POS) ? item_q.data_byte : pix_start_q;
  assign w_eff     = (pos_q == HDR_WIDTH_POS)  ? item_q.data_byte : img_w_q;
  assign h_eff     = (pos_q == HDR_HEIGHT_POS) ? item_q.data_byte : img_h_q;
  assign w_sum     = {1'b0, w_eff} + 9'd31;
  assign words     = w_sum[8:5];
  assign row_bytes = {words, 2'b00};
  assign total     = 14'(h_eff) * 14'(row_bytes);
  assign diff      = pos_q - {6'b0, ps_eff};
  assign is_pixel  = (pos_q >= {6'b0, ps_eff}) && (diff < total);
  assign is_last   = (diff == total - 14'd1);

  // quotient and remainder of the word index by words per row
  logic [10:0] n_word, q_est;
  logic [14:0] qd, rem_full;
  logic [10:0] quo_fix;
  logic [4:0]  rem_fix;

  assign n_word   = idx_q[12:2];
  assign q_est    = prod_q[RECIP_SHIFT +: 11];
  assign qd       = 15'(q_est) * 15'(words_q);
  assign rem_full = {4'b0, n_word} - qd;

  always_comb begin
    if (rem_q >= {1'b0, words_q}) begin
      quo_fix = quo_q + 11'd1;
      rem_fix = rem_q - {1'b0, words_q};
    end else begin
      quo_fix = quo_q;
      rem_fix = rem_q;
    end
  end

  // destination planning
  logic signed [10:0] h_s, r_s, oy_s, ox_s, dst_row, c0;
  logic signed [7:0]  cb, cb1;
  logic signed [15:0] dst16, cb16, base_lo, base_hi;
  logic [7:0]         pix8;
  logic [15:0]        mask16;
  logic               row_ok, lo_ok, hi_ok, clipped;

  assign h_s     = {3'b000, img_h_q};
  assign r_s     = {3'b000, src_row_q};
  assign oy_s    = {{3{off_y_q[7]}}, off_y_q};
  assign ox_s    = {{3{off_x_q[7]}}, off_x_q};
  assign dst_row = h_s - r_s - 11'sd1 + oy_s;
  assign c0      = $signed({3'b000, col_byte_q, 3'b000}) + ox_s;
  assign cb      = c0[10:3];
  assign cb1     = cb + 8'sd1;
  assign row_ok  = !dst_row[10] && (dst_row < ROWS_S);
  assign lo_ok   = row_ok && !cb[7] && (cb < COLS_S);
  assign hi_ok   = row_ok && !cb1[7] && (cb1 < COLS_S);
  assign dst16   = {{5{dst_row[10]}}, dst_row};
  assign cb16    = {{8{cb[7]}}, cb};
  assign base_lo = dst16 * RB_S + cb16;
  assign base_hi = base_lo + 16'sd1;

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      pix8[k] = !item_q.data_byte[3'(7 - k)] && ({col_byte_q, 3'(k)} < img_w_q);
    end
  end

  assign mask16  = {8'b0, pix8} << c0[2:0];
  assign clipped = ((|mask16[7:0]) && !lo_ok) || ((|mask16[15:8]) && !hi_ok);

  // framebuffer port selection
  logic [13:0]   ridx_ext;
  logic          ridx_ok;
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_wdata, ram_rdata;

  assign ridx_ext  = {4'b0, item_q.read_index};
  assign ridx_ok   = (ridx_ext < FB_BYTES_W);
  assign ram_we    = cmd_i.clr || (cmd_i.wr_lo && lo_ok_q) || (cmd_i.wr_hi && hi_ok_q);
  assign ram_waddr = cmd_i.clr ? clr_ptr_q : (cmd_i.wr_lo ? addr_lo_q : addr_hi_q);
  assign ram_wdata = cmd_i.clr ? 8'h00 :
                     (ram_rdata | (cmd_i.wr_lo ? mask_lo_q : mask_hi_q));
  assign ram_raddr = cmd_i.decode ? ridx_ext[AW-1:0] :
                     (cmd_i.rd_lo ? addr_lo_q : addr_hi_q);

  bmpblit_ram #(
    .WIDTH(8),
    .DEPTH(FB_BYTES)
  ) u_fb (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // blit context and clear pointer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      pix_start_q <= '0;
      img_w_q     <= '0;
      img_h_q     <= '0;
      off_x_q     <= '0;
      off_y_q     <= '0;
      clr_ptr_q   <= '0;
    end else begin
      if (cmd_i.clr) begin
        clr_ptr_q <= (clr_ptr_q == CLR_LAST) ? '0 : clr_ptr_q + AW'(1);
      end
      if (cmd_i.decode) begin
        case (op_e'(item_q.opcode))
          OP_BLIT: begin
            pos_q       <= '0;
            pix_start_q <= '0;
            img_w_q     <= '0;
            img_h_q     <= '0;
            off_x_q     <= item_q.dest_x;
            off_y_q     <= item_q.dest_y;
          end
          OP_BYTE: begin
            pix_start_q <= ps_eff;
            img_w_q     <= w_eff;
            img_h_q     <= h_eff;
            if (pos_q != POS_MAX) pos_q <= pos_q + 14'd1;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // per-item working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= item_i;
    end
    if (cmd_i.decode) begin
      res_q   <= '{read_data:  8'h00,
                   status:     (op_e'(item_q.opcode) == OP_BYTE && !is_pixel) ?
                               ST_NOT_PIXEL : ST_OK,
                   image_done: 1'b0};
      idx_q   <= diff[12:0];
      words_q <= words;
      done_q  <= is_last;
    end
    if (cmd_i.div1) begin
      prod_q <= 26'(n_word) * 26'(recip_of(words_q));
    end
    if (cmd_i.div2) begin
      quo_q <= q_est;
      rem_q <= rem_full[4:0];
    end
    if (cmd_i.div3) begin
      src_row_q  <= quo_fix[7:0];
      col_byte_q <= {rem_fix[2:0], idx_q[1:0]};
    end
    if (cmd_i.plan) begin
      addr_lo_q        <= base_lo[AW-1:0];
      addr_hi_q        <= base_hi[AW-1:0];
      mask_lo_q        <= mask16[7:0];
      mask_hi_q        <= mask16[15:8];
      lo_ok_q          <= lo_ok;
      hi_ok_q          <= hi_ok;
      res_q.status     <= clipped ? ST_CLIP : ST_OK;
      res_q.image_done <= done_q;
    end
    if (cmd_i.rd_cap) begin
      res_q.read_data <= ridx_ok ? ram_rdata : 8'h00;
    end
  end

  assign sts_o.op       = op_e'(item_q.opcode);
  assign sts_o.is_pixel = is_pixel;
  assign sts_o.clr_last = (clr_ptr_q == CLR_LAST);
  assign result_o       = res_q;

endmodule
